// ===== hdl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants and types of the set-associative cache model: geometry,
// configuration codes, effective configuration and the per-set row layout.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int MAX_SETS = 64;
  localparam int MAX_WAYS = 8;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int CNT_W  = 32;
  localparam int SET_W  = $clog2(MAX_SETS);
  localparam int WAY_W  = $clog2(MAX_WAYS);
  localparam int FILL_W = $clog2(MAX_WAYS + 1);

  localparam int SIB_W  = 3;
  localparam int WAYS_W = 4;
  localparam int OB_W   = 4;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIB_W-1:0] SIB_MAX = 3'd6;
  localparam logic [OB_W-1:0]  OB_MAX  = 4'd12;

  localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_FIFO       = 2'd3;

  typedef struct packed {
    logic [SIB_W-1:0]  sib;
    logic [FILL_W-1:0] ways;
    logic [OB_W-1:0]   ob;
    logic              use_fifo;
  } cfg_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0] rank;
    logic [FILL_W-1:0]              fill;
  } row_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
    row_t             row;
  } wr_req_t;

endpackage

// ===== hdl/sacl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sacl_cfg_regs
// Configuration registers with write decode, and the clamped values that the
// lookup path uses.
// ----------------------------------------------------------------------------
module sacl_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
  output sacl_pkg::cfg_t                      cfg
);
  import sacl_pkg::*;

  logic [SIB_W-1:0]  set_index_bits;
  logic [WAYS_W-1:0] ways_in_use;
  logic [OB_W-1:0]   offset_bits;
  logic              use_fifo;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= '0;
      ways_in_use    <= WAYS_W'(1);
      offset_bits    <= OB_W'(4);
      use_fifo       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SET_INDEX_BITS: set_index_bits <= cfg_data[SIB_W-1:0];
        CFG_WAYS_IN_USE:    ways_in_use    <= cfg_data[WAYS_W-1:0];
        CFG_OFFSET_BITS:    offset_bits    <= cfg_data[OB_W-1:0];
        CFG_USE_FIFO:       use_fifo       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.sib      = (set_index_bits > SIB_MAX) ? SIB_MAX : set_index_bits;
    cfg.ob       = (offset_bits > OB_MAX) ? OB_MAX : offset_bits;
    cfg.use_fifo = use_fifo;
    if (ways_in_use == '0) begin
      cfg.ways = FILL_W'(1);
    end else if (FILL_W'(ways_in_use) > FILL_W'(MAX_WAYS)) begin
      cfg.ways = FILL_W'(MAX_WAYS);
    end else begin
      cfg.ways = FILL_W'(ways_in_use);
    end
  end

endmodule

// ===== hdl/sacl_set_mem.sv =====
// ----------------------------------------------------------------------------
// sacl_set_mem
// One row per set: tags, line valids, age ranks and fill count. Registered
// read, row valid flags cleared by reset, bypass of a same-edge write.
// ----------------------------------------------------------------------------
module sacl_set_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sacl_pkg::SET_W-1:0]   rd_set,
  input  sacl_pkg::wr_req_t            wr,
  output sacl_pkg::row_t               rd_row
);
  import sacl_pkg::*;

  row_t                mem [MAX_SETS];
  row_t                mem_q;
  row_t                fwd_q;
  logic                fwd_sel;
  logic [MAX_SETS-1:0] row_valid;
  logic                row_valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set] <= wr.row;
    end
    mem_q <= mem[rd_set];
    fwd_q <= wr.row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      row_valid_q <= 1'b0;
      fwd_sel     <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.set] <= 1'b1;
      end
      row_valid_q <= row_valid[rd_set];
      fwd_sel     <= wr.en && (wr.set == rd_set);
    end
  end

  // a set never written reads as empty
  always_comb begin
    rd_row = mem_q;
    if (fwd_sel) begin
      rd_row = fwd_q;
    end else if (!row_valid_q) begin
      rd_row.valid = '0;
      rd_row.rank  = '0;
      rd_row.fill  = '0;
    end
  end

endmodule

// ===== hdl/sacl_update.sv =====
// ----------------------------------------------------------------------------
// sacl_update
// Parallel tag compare over all ways, and the new row after the access:
// LRU reorder on a hit, fill of a free way or replacement of the oldest line
// on a miss.
// ----------------------------------------------------------------------------
module sacl_update (
  input  sacl_pkg::cfg_t               cfg,
  input  logic [sacl_pkg::TAG_W-1:0]   block,
  input  sacl_pkg::row_t               row,
  output logic                         hit,
  output sacl_pkg::row_t               row_next
);
  import sacl_pkg::*;

  logic [MAX_WAYS-1:0] match;
  logic [WAY_W-1:0]    found;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    found_rank;
  logic [WAY_W-1:0]    fill_m1;
  logic                full;

  always_comb begin
    match  = '0;
    found  = '0;
    victim = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = row.valid[w] && (row.tag[w] == block);
    end
    // lowest way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        found = WAY_W'(w);
      end
      if (row.valid[w] && (row.rank[w] == '0)) begin
        victim = WAY_W'(w);
      end
    end
    hit        = |match;
    found_rank = row.rank[found];
    fill_m1    = WAY_W'(row.fill - FILL_W'(1));
    full       = (row.fill >= cfg.ways) || (row.fill >= FILL_W'(MAX_WAYS));
  end

  always_comb begin
    row_next = row;
    if (hit) begin
      if (!cfg.use_fifo) begin
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (row.valid[w] && (row.rank[w] > found_rank)) begin
            row_next.rank[w] = row.rank[w] - WAY_W'(1);
          end
        end
        row_next.rank[found] = fill_m1;
      end
    end else if (full) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (row.valid[w] && (row.rank[w] != '0)) begin
          row_next.rank[w] = row.rank[w] - WAY_W'(1);
        end
      end
      row_next.tag[victim]   = block;
      row_next.valid[victim] = 1'b1;
      row_next.rank[victim]  = fill_m1;
    end else begin
      row_next.tag[row.fill[WAY_W-1:0]]   = block;
      row_next.valid[row.fill[WAY_W-1:0]] = 1'b1;
      row_next.rank[row.fill[WAY_W-1:0]]  = row.fill[WAY_W-1:0];
      row_next.fill                       = row.fill + FILL_W'(1);
    end
  end

endmodule

// ===== hdl/set_assoc_cache_lru_fifo.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo
// Tag-only set-associative cache with LRU or FIFO replacement.
// The result strobe (done) comes from the result register, fed by the input
// register (s1). Throughput: one access per cycle, busy stays low in use;
// a set row is read and rewritten once per access, with bypass of the
// previous write when consecutive accesses hit the same set.
// Reset: busy is high for one cycle, all sets read as empty and both
// counters clear at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [sacl_pkg::ADDR_W-1:0]         address,
  input  logic                                cfg_write,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                done,
  output logic                                is_hit,
  output logic [sacl_pkg::CNT_W-1:0]          hits_so_far,
  output logic [sacl_pkg::CNT_W-1:0]          misses_so_far
);
  import sacl_pkg::*;

  cfg_t             cfg;
  logic             accept;
  logic [TAG_W-1:0] block_in;
  logic [SET_W-1:0] set_in;

  logic             s1_valid;
  logic [TAG_W-1:0] s1_block;
  logic [SET_W-1:0] s1_set;

  row_t             row;
  row_t             row_next;
  logic             hit;
  wr_req_t          wr;

  sacl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign accept   = start && !busy;
  assign block_in = TAG_W'(address >> cfg.ob);
  assign set_in   = block_in[SET_W-1:0] & ~({SET_W{1'b1}} << cfg.sib);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_block <= block_in;
    s1_set   <= set_in;
  end

  sacl_set_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_set (set_in),
    .wr     (wr),
    .rd_row (row)
  );

  sacl_update u_update (
    .cfg      (cfg),
    .block    (s1_block),
    .row      (row),
    .hit      (hit),
    .row_next (row_next)
  );

  always_comb begin
    wr.en  = s1_valid;
    wr.set = s1_set;
    wr.row = row_next;
  end

  // result register and saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      hits_so_far   <= '0;
      misses_so_far <= '0;
    end else begin
      done <= s1_valid;
      if (s1_valid) begin
        if (hit) begin
          if (hits_so_far != CNT_TOP) begin
            hits_so_far <= hits_so_far + CNT_W'(1);
          end
        end else if (misses_so_far != CNT_TOP) begin
          misses_so_far <= misses_so_far + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    is_hit <= hit;
  end

`ifndef SYNTH
  a_counts_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |=> $stable(hits_so_far) && $stable(misses_so_far))
    else $error("counters moved without an access");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> row.fill <= FILL_W'(MAX_WAYS))
    else $error("set fill beyond way count");

  a_hit_needs_lines: assert property (@(posedge clk) disable iff (rst)
    s1_valid && hit |-> row.fill != '0)
    else $error("hit in an empty set");
`endif

endmodule

// ===== verif/set_assoc_cache_lru_fifo_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_tb
// Self-checking bench for the tag-only set-associative cache. A short plan of
// register writes and accesses exercises reset state, field extremes, LRU and
// FIFO replacement, over-full sets and out-of-range settings. It is followed
// by random phases with fresh settings, access streams biased towards a small
// set of hot blocks and varied sender gaps. Each result beat is compared with
// the plan's result or an in-bench model of tags, ranks, saturating counters.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo_tb;
  import sacl_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 50;
  localparam int HOT_MAX     = 24;

  typedef struct packed {
    logic             is_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } lookup_t;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ADDR_W-1:0]     addr;
    logic                  typed;
    lookup_t               res;
  } plan_row_t;

  localparam int PLAN_LEN = 28;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0000, 1'b1, '{1'b0, 32'd0, 32'd1}},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_000F, 1'b1, '{1'b1, 32'd1, 32'd1}},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd1, 32'd2}},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0000, 1'b1, '{1'b0, 32'd1, 32'd3}},
    '{ROW_WRITE,  CFG_OFFSET_BITS,    4'd0,  32'h0000_0000, 1'b0, '0},
    '{ROW_WRITE,  CFG_WAYS_IN_USE,    4'd4,  32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0001, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0002, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0003, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0004, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0001, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0005, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0002, 1'b0, '0},
    '{ROW_WRITE,  CFG_USE_FIFO,       4'd1,  32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0004, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0006, 1'b0, '0},
    '{ROW_WRITE,  CFG_WAYS_IN_USE,    4'd2,  32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0007, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0000_0006, 1'b0, '0},
    '{ROW_WRITE,  CFG_SET_INDEX_BITS, 4'd7,  32'h0000_0000, 1'b0, '0},
    '{ROW_WRITE,  CFG_OFFSET_BITS,    4'd15, 32'h0000_0000, 1'b0, '0},
    '{ROW_WRITE,  CFG_WAYS_IN_USE,    4'd0,  32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0003_F000, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h0003_FFFF, 1'b0, '0},
    '{ROW_WRITE,  CFG_WAYS_IN_USE,    4'd15, 32'h0000_0000, 1'b0, '0},
    '{ROW_WRITE,  CFG_USE_FIFO,       4'd0,  32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_INDEX_BITS, 4'd0,  32'h8000_0000, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [ADDR_W-1:0]     address = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  done;
  logic                  is_hit;
  logic [CNT_W-1:0]      hits_so_far;
  logic [CNT_W-1:0]      misses_so_far;

  // model copy of the registers and the tag store
  logic [SIB_W-1:0]  cur_sib = 3'd0;
  logic [WAYS_W-1:0] cur_ways = 4'd1;
  logic [OB_W-1:0]   cur_ob = 4'd4;
  logic              cur_fifo = 1'b0;
  logic [TAG_W-1:0]  tag_mem [MAX_SETS][MAX_WAYS];
  bit                line_ok [MAX_SETS][MAX_WAYS];
  int                age_rank [MAX_SETS][MAX_WAYS];
  int                set_lines [MAX_SETS];
  logic [CNT_W-1:0]  hit_cnt = '0;
  logic [CNT_W-1:0]  miss_cnt = '0;

  lookup_t           pending_lookups [$];
  logic [ADDR_W-1:0] hot_blocks [HOT_MAX];
  int                fails = 0;
  int                quiet_cycles = 0;

  set_assoc_cache_lru_fifo uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .address(address),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .is_hit(is_hit), .hits_so_far(hits_so_far),
    .misses_so_far(misses_so_far)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void age_set(int s, int above);
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (line_ok[s][w] && age_rank[s][w] > above) age_rank[s][w]--;
    end
  endfunction

  function automatic lookup_t cache_lookup(logic [ADDR_W-1:0] a);
    int sib;
    int ob;
    int ways;
    int s;
    int f;
    int way;
    int victim;
    logic [TAG_W-1:0] blk;
    lookup_t r;
    sib  = int'((cur_sib > SIB_MAX) ? SIB_MAX : cur_sib);
    ob   = int'((cur_ob > OB_MAX) ? OB_MAX : cur_ob);
    ways = (cur_ways == 0) ? 1 : int'(cur_ways);
    if (ways > MAX_WAYS) ways = MAX_WAYS;
    blk = a >> ob;
    s = int'(blk & ((32'd1 << sib) - 32'd1)) % MAX_SETS;
    f = set_lines[s];
    way = -1;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way < 0 && line_ok[s][w] && tag_mem[s][w] == blk) way = w;
    end
    r.is_hit = (way >= 0);
    if (r.is_hit) begin
      if (hit_cnt != CNT_TOP) hit_cnt++;
      if (!cur_fifo) begin
        age_set(s, age_rank[s][way]);
        age_rank[s][way] = f - 1;
      end
    end else begin
      if (miss_cnt != CNT_TOP) miss_cnt++;
      if (f >= ways || f >= MAX_WAYS) begin
        // full or over-full set: oldest line goes
        victim = -1;
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (victim < 0 && line_ok[s][w] && age_rank[s][w] == 0) victim = w;
        end
        if (victim < 0) victim = 0;
        age_set(s, 0);
        tag_mem[s][victim]  = blk;
        line_ok[s][victim]  = 1'b1;
        age_rank[s][victim] = f - 1;
      end else begin
        tag_mem[s][f]  = blk;
        line_ok[s][f]  = 1'b1;
        age_rank[s][f] = f;
        set_lines[s]   = f + 1;
      end
    end
    r.hits   = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SET_INDEX_BITS: cur_sib  = val[SIB_W-1:0];
      CFG_WAYS_IN_USE:    cur_ways = val[WAYS_W-1:0];
      CFG_OFFSET_BITS:    cur_ob   = val[OB_W-1:0];
      CFG_USE_FIFO:       cur_fifo = val[0];
      default: ;
    endcase
  endtask

  task automatic send_access(logic [ADDR_W-1:0] a, int idle_pct, bit typed,
                             lookup_t typed_res);
    lookup_t r;
    cfg_write <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = cache_lookup(a);
    pending_lookups = {pending_lookups, (typed ? typed_res : r)};
  endtask

  always @(posedge clk) begin
    lookup_t want;
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        want = pending_lookups.pop_front();
        if (is_hit !== want.is_hit) begin
          $error("is_hit: expected %0d, got %0d", want.is_hit, is_hit);
          fails++;
        end
        if (hits_so_far !== want.hits) begin
          $error("hits_so_far: expected %0d, got %0d", want.hits, hits_so_far);
          fails++;
        end
        if (misses_so_far !== want.misses) begin
          $error("misses_so_far: expected %0d, got %0d", want.misses, misses_so_far);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[set_assoc_cache_lru_fifo] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle_pct;
    int pool_n;
    int eff_ob;
    logic [ADDR_W-1:0] a;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_access(PLAN[i].addr, 0, PLAN[i].typed, PLAN[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_SET_INDEX_BITS, 4'd6);
          write_reg(CFG_WAYS_IN_USE, 4'd8);
          write_reg(CFG_OFFSET_BITS, 4'd12);
          write_reg(CFG_USE_FIFO, 4'd0);
        end
        1: begin
          write_reg(CFG_SET_INDEX_BITS, 4'd0);
          write_reg(CFG_WAYS_IN_USE, 4'd1);
          write_reg(CFG_OFFSET_BITS, 4'd0);
          write_reg(CFG_USE_FIFO, 4'd1);
        end
        default: begin
          write_reg(CFG_SET_INDEX_BITS, 4'($urandom_range(0, 7)));
          write_reg(CFG_WAYS_IN_USE, 4'($urandom_range(0, 15)));
          write_reg(CFG_OFFSET_BITS, 4'($urandom_range(0, 15)));
          write_reg(CFG_USE_FIFO, 4'($urandom_range(0, 1)));
        end
      endcase
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 87 : 26;
      pool_n = $urandom_range(2, HOT_MAX);
      for (int i = 0; i < pool_n; i++) begin
        hot_blocks[i] = $urandom;
        // crowd some blocks into a few sets to force evictions
        if ($urandom_range(0, 1)) hot_blocks[i][5:0] = 6'($urandom_range(0, 3));
      end
      eff_ob = int'((cur_ob > OB_MAX) ? OB_MAX : cur_ob);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 2 && n == PHASE_BEATS / 2) begin
          wait_drained();
          @(posedge clk);
        end
        if ($urandom_range(99) < 20) begin
          a = $urandom;
        end else begin
          a = (hot_blocks[$urandom_range(0, pool_n - 1)] << eff_ob)
              | ($urandom & ((32'd1 << eff_ob) - 32'd1));
        end
        send_access(a, idle_pct, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fails == 0 && pending_lookups.size() == 0) begin
      $display("[set_assoc_cache_lru_fifo] OK");
    end else begin
      $display("[set_assoc_cache_lru_fifo] ERROR");
    end
    $finish;
  end

endmodule
